// ===== src/tqc_pkg.sv =====
// Shared constants, types and helper functions for the tiled quad clip generator.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package tqc_pkg;

    localparam int MAX_TILES_PER_AXIS = 256;
    localparam int COORD_FRAC_BITS    = 16;

    localparam int IDX_W      = 8;
    localparam int COORD_W    = 20;
    localparam int SIZE_W     = 19;
    localparam int TEX_W      = 17;
    localparam int SCALE_W    = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_ADDR_W = 3;

    // Tile offset product and the edge range that holds origin plus offset plus size.
    localparam int PROD_W = IDX_W + SIZE_W;
    localparam int EDGE_W = PROD_W + 2;
    // A clipped distance is never negative and stays below 2^(EDGE_W-1).
    localparam int DIST_W    = EDGE_W - 1;
    localparam int DIST_LO_W = DIST_W / 2;
    localparam int DIST_HI_W = DIST_W - DIST_LO_W;
    localparam int PART_W    = DIST_HI_W + SCALE_W;
    localparam int FULL_W    = DIST_W + SCALE_W;
    // A texture shift at or above 2^TEX_W saturates every result the same way.
    localparam int SHIFT_W   = TEX_W + 1;
    localparam int TSUM_W    = SHIFT_W + 2;

    localparam logic [SHIFT_W-1:0] SHIFT_CAP = SHIFT_W'(1) << TEX_W;
    localparam logic signed [TSUM_W-1:0] TEX_ONE = TSUM_W'(1) <<< (TEX_W - 1);
    localparam logic signed [EDGE_W-1:0] COORD_MIN = EDGE_W'(-(2 ** (COORD_W - 1)));
    localparam logic signed [EDGE_W-1:0] COORD_MAX = EDGE_W'((2 ** (COORD_W - 1)) - 1);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TILE_WIDTH  = 3'd0,
        CFG_TILE_HEIGHT = 3'd1,
        CFG_TEX_LEFT    = 3'd2,
        CFG_TEX_RIGHT   = 3'd3,
        CFG_TEX_TOP     = 3'd4,
        CFG_TEX_BOTTOM  = 3'd5,
        CFG_U_PER_UNIT  = 3'd6,
        CFG_V_PER_UNIT  = 3'd7
    } tqc_cfg_index_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  tile_width;
        logic [SIZE_W-1:0]  tile_height;
        logic [TEX_W-1:0]   tex_left;
        logic [TEX_W-1:0]   tex_right;
        logic [TEX_W-1:0]   tex_top;
        logic [TEX_W-1:0]   tex_bottom;
        logic [SCALE_W-1:0] u_per_unit;
        logic [SCALE_W-1:0] v_per_unit;
    } tqc_cfg_t;

    // Register load enables for the three stages of one pipeline section.
    typedef struct packed {
        logic first;
        logic mid;
        logic last;
    } tqc_load_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] bottom;
    } tqc_edges_t;

    typedef struct packed {
        tqc_edges_t        quad;
        logic [DIST_W-1:0] dist_left;
        logic [DIST_W-1:0] dist_right;
        logic [DIST_W-1:0] dist_top;
        logic [DIST_W-1:0] dist_bottom;
    } tqc_clip_t;

    typedef struct packed {
        tqc_edges_t       quad;
        logic [TEX_W-1:0] u_left;
        logic [TEX_W-1:0] u_right;
        logic [TEX_W-1:0] v_top;
        logic [TEX_W-1:0] v_bottom;
    } tqc_quad_t;

    function automatic logic signed [EDGE_W-1:0] ext_coord(input logic signed [COORD_W-1:0] v);
        return {{(EDGE_W - COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [EDGE_W-1:0] v);
        logic signed [EDGE_W-1:0] r;
        r = v;
        if (v < COORD_MIN) begin
            r = COORD_MIN;
        end else if (v > COORD_MAX) begin
            r = COORD_MAX;
        end
        return r[COORD_W-1:0];
    endfunction

    function automatic logic [TEX_W-1:0] sat_tex(input logic signed [TSUM_W-1:0] v);
        logic signed [TSUM_W-1:0] r;
        r = v;
        if (v < 0) begin
            r = '0;
        end else if (v > TEX_ONE) begin
            r = TEX_ONE;
        end
        return r[TEX_W-1:0];
    endfunction

endpackage

// ===== src/tqc_cfg_regs.sv =====
// Configuration register file: tile size, texture edges and texture scale.
// Depends on tqc_pkg for the register layout and index codes.
`timescale 1ns / 1ps

module tqc_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [tqc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [tqc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output tqc_pkg::tqc_cfg_t                   cfg
);

    tqc_pkg::tqc_cfg_t cfg_reg;
    tqc_pkg::tqc_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (tqc_pkg::tqc_cfg_index_t'(cfg_addr))
                tqc_pkg::CFG_TILE_WIDTH:  cfg_next.tile_width  = cfg_wdata[tqc_pkg::SIZE_W-1:0];
                tqc_pkg::CFG_TILE_HEIGHT: cfg_next.tile_height = cfg_wdata[tqc_pkg::SIZE_W-1:0];
                tqc_pkg::CFG_TEX_LEFT:    cfg_next.tex_left    = cfg_wdata[tqc_pkg::TEX_W-1:0];
                tqc_pkg::CFG_TEX_RIGHT:   cfg_next.tex_right   = cfg_wdata[tqc_pkg::TEX_W-1:0];
                tqc_pkg::CFG_TEX_TOP:     cfg_next.tex_top     = cfg_wdata[tqc_pkg::TEX_W-1:0];
                tqc_pkg::CFG_TEX_BOTTOM:  cfg_next.tex_bottom  = cfg_wdata[tqc_pkg::TEX_W-1:0];
                tqc_pkg::CFG_U_PER_UNIT:  cfg_next.u_per_unit  = cfg_wdata[tqc_pkg::SCALE_W-1:0];
                tqc_pkg::CFG_V_PER_UNIT:  cfg_next.v_per_unit  = cfg_wdata[tqc_pkg::SCALE_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tile_width  <= tqc_pkg::SIZE_W'(65536);
            cfg_reg.tile_height <= tqc_pkg::SIZE_W'(65536);
            cfg_reg.tex_left    <= '0;
            cfg_reg.tex_right   <= tqc_pkg::TEX_W'(65536);
            cfg_reg.tex_top     <= '0;
            cfg_reg.tex_bottom  <= tqc_pkg::TEX_W'(65536);
            cfg_reg.u_per_unit  <= tqc_pkg::SCALE_W'(65536);
            cfg_reg.v_per_unit  <= tqc_pkg::SCALE_W'(65536);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/tqc_edge_pipe.sv =====
// Geometry section: tile offset products, tile edges, then scissor clip and rejection.
// Depends on tqc_pkg; stage loads come from the top-level handshake control.
`timescale 1ns / 1ps

module tqc_edge_pipe (
    input  logic                                aclk,
    input  tqc_pkg::tqc_load_t                  load,
    input  tqc_pkg::tqc_cfg_t                   cfg,
    input  logic [tqc_pkg::IDX_W-1:0]           tile_column,
    input  logic [tqc_pkg::IDX_W-1:0]           tile_row,
    input  logic signed [tqc_pkg::COORD_W-1:0]  origin_x,
    input  logic signed [tqc_pkg::COORD_W-1:0]  origin_y,
    input  logic signed [tqc_pkg::COORD_W-1:0]  clip_left,
    input  logic signed [tqc_pkg::COORD_W-1:0]  clip_right,
    input  logic signed [tqc_pkg::COORD_W-1:0]  clip_top,
    input  logic signed [tqc_pkg::COORD_W-1:0]  clip_bottom,
    output tqc_pkg::tqc_clip_t                  clip,
    output logic                                keep
);

    // Stage 1: offsets along each axis.
    logic [tqc_pkg::PROD_W-1:0]          col_prod_reg, row_prod_reg;
    logic [tqc_pkg::PROD_W-1:0]          col_prod_next, row_prod_next;
    logic signed [tqc_pkg::COORD_W-1:0]  ox1_reg, oy1_reg;
    logic signed [tqc_pkg::COORD_W-1:0]  cl1_reg, cr1_reg, ct1_reg, cb1_reg;
    logic                                in_range1_reg, in_range1_next;

    // Stage 2: unclipped tile edges.
    logic signed [tqc_pkg::EDGE_W-1:0]   left2_reg, right2_reg, top2_reg, bottom2_reg;
    logic signed [tqc_pkg::EDGE_W-1:0]   left2_next, right2_next, top2_next, bottom2_next;
    logic signed [tqc_pkg::EDGE_W-1:0]   cl2_reg, cr2_reg, ct2_reg, cb2_reg;
    logic                                in_range2_reg;

    // Stage 3: clipped quad.
    tqc_pkg::tqc_clip_t                  clip3_reg, clip3_next;
    logic                                keep3_reg, keep3_next;

    logic signed [tqc_pkg::EDGE_W-1:0]   col_off, row_off, width_e, height_e;
    logic signed [tqc_pkg::EDGE_W-1:0]   ql, qr, qt, qb;
    logic signed [tqc_pkg::EDGE_W-1:0]   diff_l, diff_r, diff_t, diff_b;
    logic                                cut_l, cut_r, cut_t, cut_b, reject;

    always_comb begin
        col_prod_next  = tqc_pkg::PROD_W'(tile_column) * tqc_pkg::PROD_W'(cfg.tile_width);
        row_prod_next  = tqc_pkg::PROD_W'(tile_row) * tqc_pkg::PROD_W'(cfg.tile_height);
        in_range1_next = (32'(tile_column) < tqc_pkg::MAX_TILES_PER_AXIS) &&
                         (32'(tile_row) < tqc_pkg::MAX_TILES_PER_AXIS);
    end

    always_comb begin
        col_off  = {{(tqc_pkg::EDGE_W - tqc_pkg::PROD_W){1'b0}}, col_prod_reg};
        row_off  = {{(tqc_pkg::EDGE_W - tqc_pkg::PROD_W){1'b0}}, row_prod_reg};
        width_e  = {{(tqc_pkg::EDGE_W - tqc_pkg::SIZE_W){1'b0}}, cfg.tile_width};
        height_e = {{(tqc_pkg::EDGE_W - tqc_pkg::SIZE_W){1'b0}}, cfg.tile_height};
        // Screen y decreases going down, so rows step the top edge downward.
        left2_next   = tqc_pkg::ext_coord(ox1_reg) + col_off;
        right2_next  = left2_next + width_e;
        top2_next    = tqc_pkg::ext_coord(oy1_reg) - row_off;
        bottom2_next = top2_next - height_e;
    end

    always_comb begin
        cut_l = left2_reg < cl2_reg;
        cut_r = right2_reg > cr2_reg;
        cut_t = top2_reg > ct2_reg;
        cut_b = bottom2_reg < cb2_reg;

        ql = cut_l ? cl2_reg : left2_reg;
        qr = cut_r ? cr2_reg : right2_reg;
        qt = cut_t ? ct2_reg : top2_reg;
        qb = cut_b ? cb2_reg : bottom2_reg;

        // Only the right and bottom tests look at the near edge already clipped.
        reject = (cut_l && (right2_reg < cl2_reg)) || (cut_r && (ql > cr2_reg)) ||
                 (cut_t && (bottom2_reg > ct2_reg)) || (cut_b && (qt < cb2_reg));

        diff_l = cl2_reg - left2_reg;
        diff_r = right2_reg - cr2_reg;
        diff_t = top2_reg - ct2_reg;
        diff_b = cb2_reg - bottom2_reg;

        clip3_next.quad.left   = tqc_pkg::sat_coord(ql);
        clip3_next.quad.right  = tqc_pkg::sat_coord(qr);
        clip3_next.quad.top    = tqc_pkg::sat_coord(qt);
        clip3_next.quad.bottom = tqc_pkg::sat_coord(qb);
        clip3_next.dist_left   = cut_l ? diff_l[tqc_pkg::DIST_W-1:0] : '0;
        clip3_next.dist_right  = cut_r ? diff_r[tqc_pkg::DIST_W-1:0] : '0;
        clip3_next.dist_top    = cut_t ? diff_t[tqc_pkg::DIST_W-1:0] : '0;
        clip3_next.dist_bottom = cut_b ? diff_b[tqc_pkg::DIST_W-1:0] : '0;
        keep3_next             = in_range2_reg && !reject;
    end

    always_ff @(posedge aclk) begin
        if (load.first) begin
            col_prod_reg  <= col_prod_next;
            row_prod_reg  <= row_prod_next;
            ox1_reg       <= origin_x;
            oy1_reg       <= origin_y;
            cl1_reg       <= clip_left;
            cr1_reg       <= clip_right;
            ct1_reg       <= clip_top;
            cb1_reg       <= clip_bottom;
            in_range1_reg <= in_range1_next;
        end
        if (load.mid) begin
            left2_reg     <= left2_next;
            right2_reg    <= right2_next;
            top2_reg      <= top2_next;
            bottom2_reg   <= bottom2_next;
            cl2_reg       <= tqc_pkg::ext_coord(cl1_reg);
            cr2_reg       <= tqc_pkg::ext_coord(cr1_reg);
            ct2_reg       <= tqc_pkg::ext_coord(ct1_reg);
            cb2_reg       <= tqc_pkg::ext_coord(cb1_reg);
            in_range2_reg <= in_range1_reg;
        end
        if (load.last) begin
            clip3_reg <= clip3_next;
            keep3_reg <= keep3_next;
        end
    end

    assign clip = clip3_reg;
    assign keep = keep3_reg;

endmodule

// ===== src/tqc_tex_pipe.sv =====
// Texture section: split products of clip distance and scale, rounding, saturation.
// Depends on tqc_pkg; its last stage is the block's output register.
`timescale 1ns / 1ps

module tqc_tex_pipe (
    input  logic                aclk,
    input  tqc_pkg::tqc_load_t  load,
    input  tqc_pkg::tqc_cfg_t   cfg,
    input  tqc_pkg::tqc_clip_t  clip,
    output tqc_pkg::tqc_quad_t  quad
);

    localparam int NUM_EDGES = 4;

    logic [tqc_pkg::DIST_W-1:0]  span [NUM_EDGES];
    logic [tqc_pkg::SCALE_W-1:0] scale [NUM_EDGES];

    // Stage 4: partial products of the low and high halves of each distance.
    logic [tqc_pkg::PART_W-1:0]  prod_lo_reg [NUM_EDGES];
    logic [tqc_pkg::PART_W-1:0]  prod_hi_reg [NUM_EDGES];
    logic [tqc_pkg::PART_W-1:0]  prod_lo_next [NUM_EDGES];
    logic [tqc_pkg::PART_W-1:0]  prod_hi_next [NUM_EDGES];
    tqc_pkg::tqc_edges_t         quad4_reg;

    // Stage 5: rounded shift, capped where it saturates anyway.
    logic [tqc_pkg::FULL_W-1:0]  full [NUM_EDGES];
    logic [tqc_pkg::FULL_W-1:0]  shift_full [NUM_EDGES];
    logic [tqc_pkg::SHIFT_W-1:0] shift_reg [NUM_EDGES];
    logic [tqc_pkg::SHIFT_W-1:0] shift_next [NUM_EDGES];
    tqc_pkg::tqc_edges_t         quad5_reg;

    // Stage 6: output register.
    tqc_pkg::tqc_quad_t          out_reg, out_next;

    logic signed [tqc_pkg::TSUM_W-1:0] sum_l, sum_r, sum_t, sum_b;

    always_comb begin
        span[0]  = clip.dist_left;
        span[1]  = clip.dist_right;
        span[2]  = clip.dist_top;
        span[3]  = clip.dist_bottom;
        scale[0] = cfg.u_per_unit;
        scale[1] = cfg.u_per_unit;
        scale[2] = cfg.v_per_unit;
        scale[3] = cfg.v_per_unit;
        for (int i = 0; i < NUM_EDGES; i++) begin
            prod_lo_next[i] = tqc_pkg::PART_W'(span[i][tqc_pkg::DIST_LO_W-1:0]) *
                              tqc_pkg::PART_W'(scale[i]);
            prod_hi_next[i] = tqc_pkg::PART_W'(span[i][tqc_pkg::DIST_W-1:tqc_pkg::DIST_LO_W]) *
                              tqc_pkg::PART_W'(scale[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_EDGES; i++) begin
            full[i] = (tqc_pkg::FULL_W'(prod_hi_reg[i]) << tqc_pkg::DIST_LO_W) +
                      tqc_pkg::FULL_W'(prod_lo_reg[i]) +
                      (tqc_pkg::FULL_W'(1) << (tqc_pkg::COORD_FRAC_BITS - 1));
            shift_full[i] = full[i] >> tqc_pkg::COORD_FRAC_BITS;
            shift_next[i] = (shift_full[i] > tqc_pkg::FULL_W'(tqc_pkg::SHIFT_CAP)) ?
                            tqc_pkg::SHIFT_CAP : shift_full[i][tqc_pkg::SHIFT_W-1:0];
        end
    end

    always_comb begin
        // Left and top move inward by adding, right and bottom by subtracting.
        sum_l = {{(tqc_pkg::TSUM_W - tqc_pkg::TEX_W){1'b0}}, cfg.tex_left} +
                {{(tqc_pkg::TSUM_W - tqc_pkg::SHIFT_W){1'b0}}, shift_reg[0]};
        sum_r = {{(tqc_pkg::TSUM_W - tqc_pkg::TEX_W){1'b0}}, cfg.tex_right} -
                {{(tqc_pkg::TSUM_W - tqc_pkg::SHIFT_W){1'b0}}, shift_reg[1]};
        sum_t = {{(tqc_pkg::TSUM_W - tqc_pkg::TEX_W){1'b0}}, cfg.tex_top} +
                {{(tqc_pkg::TSUM_W - tqc_pkg::SHIFT_W){1'b0}}, shift_reg[2]};
        sum_b = {{(tqc_pkg::TSUM_W - tqc_pkg::TEX_W){1'b0}}, cfg.tex_bottom} -
                {{(tqc_pkg::TSUM_W - tqc_pkg::SHIFT_W){1'b0}}, shift_reg[3]};
        out_next.quad     = quad5_reg;
        out_next.u_left   = tqc_pkg::sat_tex(sum_l);
        out_next.u_right  = tqc_pkg::sat_tex(sum_r);
        out_next.v_top    = tqc_pkg::sat_tex(sum_t);
        out_next.v_bottom = tqc_pkg::sat_tex(sum_b);
    end

    always_ff @(posedge aclk) begin
        if (load.first) begin
            for (int i = 0; i < NUM_EDGES; i++) begin
                prod_lo_reg[i] <= prod_lo_next[i];
                prod_hi_reg[i] <= prod_hi_next[i];
            end
            quad4_reg <= clip.quad;
        end
        if (load.mid) begin
            for (int i = 0; i < NUM_EDGES; i++) begin
                shift_reg[i] <= shift_next[i];
            end
            quad5_reg <= quad4_reg;
        end
        if (load.last) begin
            out_reg <= out_next;
        end
    end

    assign quad = out_reg;

endmodule

// ===== src/tiled_quad_clip_generator.sv =====
// Tiled quad clip generator: six-stage pipeline. Throughput one word per cycle while
// m_ready is high; a tile that is clipped away leaves a bubble and no result.
// Each stage advances when it is empty or the stage after it advances, so a stall at
// the output fills the pipeline before s_ready drops and nothing is lost or repeated.
// Reset (aresetn, synchronous, active low) empties the pipeline and loads the register
// defaults: tile size 1.0, texture edges 0 and 1.0, texture scale 1.0 per unit.
`timescale 1ns / 1ps

module tiled_quad_clip_generator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [tqc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [tqc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [tqc_pkg::IDX_W-1:0]           s_tile_column,
    input  logic [tqc_pkg::IDX_W-1:0]           s_tile_row,
    input  logic signed [tqc_pkg::COORD_W-1:0]  s_origin_x,
    input  logic signed [tqc_pkg::COORD_W-1:0]  s_origin_y,
    input  logic signed [tqc_pkg::COORD_W-1:0]  s_clip_left,
    input  logic signed [tqc_pkg::COORD_W-1:0]  s_clip_right,
    input  logic signed [tqc_pkg::COORD_W-1:0]  s_clip_top,
    input  logic signed [tqc_pkg::COORD_W-1:0]  s_clip_bottom,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tqc_pkg::COORD_W-1:0]  m_quad_left,
    output logic signed [tqc_pkg::COORD_W-1:0]  m_quad_right,
    output logic signed [tqc_pkg::COORD_W-1:0]  m_quad_top,
    output logic signed [tqc_pkg::COORD_W-1:0]  m_quad_bottom,
    output logic [tqc_pkg::TEX_W-1:0]           m_u_left,
    output logic [tqc_pkg::TEX_W-1:0]           m_u_right,
    output logic [tqc_pkg::TEX_W-1:0]           m_v_top,
    output logic [tqc_pkg::TEX_W-1:0]           m_v_bottom
);

    localparam int NUM_STAGES = 6;

    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] stage_en;
    logic                  keep;

    tqc_pkg::tqc_cfg_t     cfg;
    tqc_pkg::tqc_load_t    edge_load, tex_load;
    tqc_pkg::tqc_clip_t    clip;
    tqc_pkg::tqc_quad_t    quad;

    always_comb begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (stage_en[0]) valid_next[0] = s_valid;
        if (stage_en[1]) valid_next[1] = valid_reg[0];
        if (stage_en[2]) valid_next[2] = valid_reg[1];
        // A rejected tile leaves the pipeline after the clip stage.
        if (stage_en[3]) valid_next[3] = valid_reg[2] && keep;
        if (stage_en[4]) valid_next[4] = valid_reg[3];
        if (stage_en[5]) valid_next[5] = valid_reg[4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign edge_load = '{first: stage_en[0], mid: stage_en[1], last: stage_en[2]};
    assign tex_load  = '{first: stage_en[3], mid: stage_en[4], last: stage_en[5]};

    tqc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tqc_edge_pipe u_edge (
        .aclk        (aclk),
        .load        (edge_load),
        .cfg         (cfg),
        .tile_column (s_tile_column),
        .tile_row    (s_tile_row),
        .origin_x    (s_origin_x),
        .origin_y    (s_origin_y),
        .clip_left   (s_clip_left),
        .clip_right  (s_clip_right),
        .clip_top    (s_clip_top),
        .clip_bottom (s_clip_bottom),
        .clip        (clip),
        .keep        (keep)
    );

    tqc_tex_pipe u_tex (
        .aclk (aclk),
        .load (tex_load),
        .cfg  (cfg),
        .clip (clip),
        .quad (quad)
    );

    assign s_ready       = stage_en[0];
    assign m_valid       = valid_reg[NUM_STAGES-1];
    assign m_quad_left   = quad.quad.left;
    assign m_quad_right  = quad.quad.right;
    assign m_quad_top    = quad.quad.top;
    assign m_quad_bottom = quad.quad.bottom;
    assign m_u_left      = quad.u_left;
    assign m_u_right     = quad.u_right;
    assign m_v_top       = quad.v_top;
    assign m_v_bottom    = quad.v_bottom;

endmodule
